[design/spbp_pkg.sv]
// ----------------------------------------------------------------------------
// spbp_pkg
// Shared types, constants and the pixel packing function of the sprite
// bitplane to packed nibble converter.
// ----------------------------------------------------------------------------
package spbp_pkg;

    localparam int unsigned WORD_W     = 32;
    localparam int unsigned ROW_W      = 64;
    localparam int unsigned POS_W      = 5;
    localparam int unsigned BUF_IDX_W  = 4;
    localparam int unsigned BUF_DEPTH  = 16;
    localparam logic [BUF_IDX_W-1:0] LAST_ROW = 4'd15;
    localparam logic [POS_W-1:0]     LAST_POS = 5'd31;

    typedef struct packed {
        logic [WORD_W-1:0] cur_word;
        logic [WORD_W-1:0] buf_word;
        logic              sprite_end;
        logic              sprite_used;
    } t_row_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // nibble x = {p3[x], p1[x], p2[x], p0[x]}
    function automatic logic [WORD_W-1:0] pack_eight(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] acc;
        acc = '0;
        for (int x = 0; x < 8; x++) begin
            acc[4*x+3] = w[24+x];
            acc[4*x+2] = w[8+x];
            acc[4*x+1] = w[16+x];
            acc[4*x]   = w[x];
        end
        return acc;
    endfunction

endpackage

[design/spbp_if.sv]
// ----------------------------------------------------------------------------
// spbp_if
// Valid/ready channels: plane word input and packed row output.
// ----------------------------------------------------------------------------
interface spbp_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] plane_word;

    modport source (output valid, output plane_word, input ready);
    modport sink   (input valid, input plane_word, output ready);
endinterface

interface spbp_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] row_pixels;
    logic        sprite_end;
    logic        sprite_used;

    modport source (output valid, output row_pixels, output sprite_end,
                    output sprite_used, input ready);
    modport sink   (input valid, input row_pixels, input sprite_end,
                    input sprite_used, output ready);
endinterface

[design/spbp_front.sv]
// ----------------------------------------------------------------------------
// spbp_front
// Accepts plane words, tracks sprite position and usage, buffers the first
// half of each sprite and issues one row job per second-half word.
// ----------------------------------------------------------------------------
module spbp_front
    import spbp_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    spbp_in_if.sink         i_in,
    input  t_q_status       i_q_status,
    output logic            o_push,
    output t_row_job        o_push_job
);

    logic [POS_W-1:0]  r_pos;
    logic [POS_W-1:0]  n_pos;
    logic              r_any;
    logic              n_any;
    logic [WORD_W-1:0] r_buf [BUF_DEPTH];

    logic              accept;
    logic              used;
    logic              last;
    logic              second_half;

    assign second_half = r_pos[POS_W-1];
    assign i_in.ready  = !second_half || !i_q_status.full;
    assign accept      = i_in.valid && i_in.ready;
    assign used        = r_any || (i_in.plane_word != '0);
    assign last        = (r_pos[BUF_IDX_W-1:0] == LAST_ROW);

    assign o_push                 = i_in.valid && second_half && !i_q_status.full;
    assign o_push_job.cur_word    = i_in.plane_word;
    assign o_push_job.buf_word    = r_buf[r_pos[BUF_IDX_W-1:0]];
    assign o_push_job.sprite_end  = last;
    assign o_push_job.sprite_used = last && used;

    always_comb begin
        n_pos = r_pos;
        n_any = r_any;
        if (accept) begin
            n_pos = r_pos + POS_W'(1);
            if (second_half && last) begin
                n_any = 1'b0;
            end else begin
                n_any = used;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_any <= 1'b0;
        end else begin
            r_pos <= n_pos;
            r_any <= n_any;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && !second_half) begin
            r_buf[r_pos[BUF_IDX_W-1:0]] <= i_in.plane_word;
        end
    end

    a_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_pos == LAST_POS) |=> (r_pos == '0 && !r_any))
        else $error("sprite did not wrap cleanly");

    a_first_half_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !second_half |-> i_in.ready)
        else $error("first-half word stalled");

    a_push_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (accept && second_half))
        else $error("row job pushed without a second-half item");

endmodule

[design/spbp_queue.sv]
// ----------------------------------------------------------------------------
// spbp_queue
// Small FIFO of row jobs between the front and back parts.
// ----------------------------------------------------------------------------
module spbp_queue
    import spbp_pkg::*;
#(
    parameter int unsigned DEPTH = 2
)
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_row_job  i_push_job,
    input  logic      i_pop,
    output t_row_job  o_head,
    output t_q_status o_status
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_row_job          r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic [PTR_W-1:0]  n_wr_ptr;
    logic [PTR_W-1:0]  n_rd_ptr;
    logic [CNT_W-1:0]  n_count;

    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_head         = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + CNT_W'(1);
            2'b01:   n_count = r_count - CNT_W'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_job;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_status.full))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_status.empty))
        else $error("pop from empty queue");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("queue count did not advance");

endmodule

[design/spbp_back.sv]
// ----------------------------------------------------------------------------
// spbp_back
// Packs row jobs into sixteen 4-bit pixels and holds the result in an
// output register.
// ----------------------------------------------------------------------------
module spbp_back
    import spbp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_row_job    i_head,
    input  t_q_status   i_q_status,
    output logic        o_pop,
    spbp_out_if.source  o_out
);

    logic             r_valid;
    logic             n_valid;
    logic [ROW_W-1:0] r_row;
    logic             r_end;
    logic             r_used;

    assign o_pop = !i_q_status.empty && (!r_valid || o_out.ready);

    always_comb begin
        n_valid = r_valid;
        if (o_pop) begin
            n_valid = 1'b1;
        end else if (o_out.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_row  <= {pack_eight(i_head.buf_word), pack_eight(i_head.cur_word)};
            r_end  <= i_head.sprite_end;
            r_used <= i_head.sprite_used;
        end
    end

    assign o_out.valid       = r_valid;
    assign o_out.row_pixels  = r_row;
    assign o_out.sprite_end  = r_end;
    assign o_out.sprite_used = r_used;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !o_out.ready) |=> (r_valid && $stable(r_row)))
        else $error("stalled row changed");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> !i_q_status.empty)
        else $error("pop from empty queue");

    a_pop_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_valid)
        else $error("popped row not presented");

endmodule

[design/sprite_bitplane_to_packed_nibbles_unit.sv]
// ----------------------------------------------------------------------------
// sprite_bitplane_to_packed_nibbles_unit
// Planar to packed 4bpp converter for 16x16 sprites, 32 words per sprite.
// ----------------------------------------------------------------------------
// Takes one 32-bit plane word per cycle while not stalled. Words 0..15 of
// each sprite fill a 16-entry half buffer and give no result; word 16+k gives
// row k as 64 bits (low half from the word itself, high half from buffered
// word k), pixel x = {b3,b1,b2,b0}[x]. Row 15 carries sprite_end and
// sprite_used (any nonzero byte in the sprite). A row job is pushed into the
// job queue as its word is accepted, then popped into the output register,
// which holds it under output stall. The front stalls only on second-half
// words, when the QUEUE_DEPTH-entry job queue is full.
// ----------------------------------------------------------------------------
module sprite_bitplane_to_packed_nibbles_unit
    import spbp_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 2
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    spbp_in_if.sink     i_in,
    spbp_out_if.source  o_out
);

    logic      push;
    t_row_job  push_job;
    logic      pop;
    t_row_job  head;
    t_q_status q_status;

    spbp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_q_status (q_status),
        .o_push     (push),
        .o_push_job (push_job)
    );

    spbp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_job (push_job),
        .i_pop      (pop),
        .o_head     (head),
        .o_status   (q_status)
    );

    spbp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head),
        .i_q_status (q_status),
        .o_pop      (pop),
        .o_out      (o_out)
    );

endmodule
